// ===== hw/rtl/i2da_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2da_pkg
// shared types and constants for the integer to decimal ascii converter
// ----------------------------------------------------------------------------
package i2da_pkg;

   localparam int IN_WIDTH    = 64;
   localparam int CHAR_WIDTH  = 7;
   localparam int LEN_WIDTH   = 5;
   localparam int DIGIT_WIDTH = 4;

   localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO    = 7'd48;
   localparam logic [CHAR_WIDTH-1:0]  CHAR_MINUS   = 7'd45;
   localparam logic [DIGIT_WIDTH-1:0] ADJUST_LIMIT = 4'd5;
   localparam logic [DIGIT_WIDTH-1:0] ADJUST_ADD   = 4'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   // control broadcast to every digit cell
   typedef struct packed {
      logic clear;
      logic step;
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/i2da_digit_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2da_digit_cell
// one bcd digit of the shift-and-add-3 chain
// ----------------------------------------------------------------------------
module i2da_digit_cell
   import i2da_pkg::*;
(
   input  logic                   clock,
   input  cell_ctrl_type          ctrl,
   input  logic                   carry_in,
   output logic                   carry_out,
   output logic [DIGIT_WIDTH-1:0] digit
);

   logic [DIGIT_WIDTH-1:0] digit_ff;
   logic [DIGIT_WIDTH-1:0] digit_in;
   logic [DIGIT_WIDTH-1:0] adjusted;

   // add 3 before the shift when the digit would overflow past 9
   assign adjusted  = (digit_ff >= ADJUST_LIMIT) ? digit_ff + ADJUST_ADD : digit_ff;
   assign carry_out = adjusted[DIGIT_WIDTH-1];
   assign digit     = digit_ff;

   always_comb begin
      digit_in = digit_ff;
      if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.step) begin
         digit_in = {adjusted[DIGIT_WIDTH-2:0], carry_in};
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

// ===== hw/rtl/integer_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii
// binary word to decimal ascii text, one character per transaction
// ----------------------------------------------------------------------------
// A word of VALUE_WIDTH bits (low bits of req_value) is read as unsigned, or
// as two's complement when req_action is 1, and comes out as its decimal
// text, most significant character first, no leading zeros, '-' in front of
// a negative value and '0' for zero. Every character carries the total text
// length and rsp_last marks the final digit. One word is converted at a
// time: the request transaction is taken, the magnitude then shifts one
// bit per cycle through a row of bcd digit cells, and the characters leave
// one per cycle, while rsp_stall is low, through a single output register.
// The next word is taken as soon as the last character sits in the output
// register, even while that character is still stalled.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii
   import i2da_pkg::*;
#(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [IN_WIDTH-1:0]   req_value,
   input  logic                  req_action,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHAR_WIDTH-1:0] rsp_char_code,
   output logic [LEN_WIDTH-1:0]  rsp_text_length,
   output logic                  rsp_last
);

   // digits needed for 2^VALUE_WIDTH - 1 (1233/4096 just under log10 2)
   localparam int NDIG      = (VALUE_WIDTH * 1233) / 4096 + 1;
   localparam int CNT_WIDTH = $clog2(NDIG + 1);
   localparam int IDX_WIDTH = $clog2(NDIG);
   localparam int BIT_WIDTH = $clog2(VALUE_WIDTH);

   state_type state_ff, state_in;

   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [BIT_WIDTH-1:0]   bit_ff, bit_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic [IDX_WIDTH-1:0]   pos_ff, pos_in;
   logic                   sign_ff, sign_in;
   logic [LEN_WIDTH-1:0]   text_len_ff, text_len_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0] rsp_char_ff, rsp_char_in;
   logic [LEN_WIDTH-1:0]  rsp_len_ff, rsp_len_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                   req_accept;
   logic                   rsp_load;
   logic [VALUE_WIDTH-1:0] word;
   logic                   negative;
   logic [CNT_WIDTH-1:0]   ndig;
   cell_ctrl_type          cell_ctrl;

   // carry_w[k] enters cell k; carry_w[0] is the next magnitude bit
   logic                   carry_w [NDIG+1];
   logic [DIGIT_WIDTH-1:0] digit_w [NDIG];

   // ---------------------------------------------------------------------
   // handshakes
   // ---------------------------------------------------------------------
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   // output register free or being emptied this cycle
   assign rsp_load   = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   assign word     = req_value[VALUE_WIDTH-1:0];
   assign negative = req_action && word[VALUE_WIDTH-1];

   assign cell_ctrl.clear = req_accept;
   assign cell_ctrl.step  = (state_ff == ST_CONVERT);

   // ---------------------------------------------------------------------
   // row of bcd digit cells, least significant digit at index 0
   // ---------------------------------------------------------------------
   assign carry_w[0] = mag_ff[VALUE_WIDTH-1];

   for (genvar k = 0; k < NDIG; k++) begin : g_cell
      i2da_digit_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .carry_in  (carry_w[k]),
         .carry_out (carry_w[k+1]),
         .digit     (digit_w[k])
      );
   end

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      mag_in      = mag_ff;
      bit_in      = bit_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      sign_in     = sign_ff;
      text_len_in = text_len_ff;
      ndig        = '0;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               mag_in   = negative ? (~word + 1'b1) : word;
               sign_in  = negative;
               bit_in   = BIT_WIDTH'(VALUE_WIDTH - 1);
               count_in = '0;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            mag_in = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            // occupied digits grow by at most one cell per shift
            if (carry_w[count_ff]) begin
               count_in = count_ff + 1'b1;
            end
            if (bit_ff == '0) begin
               ndig        = (count_in == '0) ? CNT_WIDTH'(1) : count_in;
               pos_in      = IDX_WIDTH'(ndig - 1'b1);
               text_len_in = LEN_WIDTH'(ndig) + LEN_WIDTH'(sign_ff);
               state_in    = ST_EMIT;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_len_in   = text_len_ff;
               if (sign_ff) begin
                  rsp_char_in = CHAR_MINUS;
                  rsp_last_in = 1'b0;
                  sign_in     = 1'b0;
               end else begin
                  rsp_char_in = CHAR_ZERO + CHAR_WIDTH'(digit_w[pos_ff]);
                  rsp_last_in = (pos_ff == '0);
                  if (pos_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     pos_in = pos_ff - 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bit_ff      <= bit_in;
      count_ff    <= count_in;
      pos_ff      <= pos_in;
      sign_ff     <= sign_in;
      text_len_ff <= text_len_in;
      rsp_char_ff <= rsp_char_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_char_code   = rsp_char_ff;
   assign rsp_text_length = rsp_len_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
